// File: src/bf3_pkg.sv
`default_nettype none

package bf3_pkg;

   localparam int ROW_W       = 16;
   localparam int COL_W       = 10;
   localparam int OUT_VALUE_W = 24;
   localparam int WIDTH_REG_W = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;

   localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd64;
   localparam logic [ROW_W-1:0] HEIGHT_MIN   = 16'd3;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col_a;
      logic [COL_W-1:0] col_b;
      logic [COL_W-1:0] col_c;
      logic             emit_a;
      logic             emit_b;
      logic             emit_c;
      logic             interior;
      logic             endcol;
      logic             last;
   } meta_type;

endpackage

`default_nettype wire

// File: src/bf3_window.sv
`default_nettype none

module bf3_window #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
   input  logic [bf3_pkg::ROW_W-1:0]     hlast,
   input  logic                          in_valid,
   input  logic [VALUE_BITS-1:0]         in_sample,
   output logic                          in_ready,
   output logic                          out_valid,
   output logic [VALUE_BITS+3:0]         out_sum,
   output bf3_pkg::meta_type             out_meta,
   input  logic                          out_ready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int VW  = VALUE_BITS;
   localparam int CSW = VW + 2;
   localparam int PW  = CSW + 1;
   localparam int SW  = VW + 4;

   logic [2*VW-1:0] line_mem [MAX_WIDTH];

   logic [CW-1:0]             col_ff;
   logic [bf3_pkg::ROW_W-1:0] row_ff;

   logic                      s1_valid_ff;
   logic [VW-1:0]             s1_x_ff;
   logic [CW-1:0]             s1_addr_ff;
   bf3_pkg::meta_type         s1_meta_ff;
   logic [2*VW-1:0]           rd_ff;

   logic [CSW-1:0]            prev_ff;
   logic [CSW-1:0]            prev2_ff;

   logic                      s2_valid_ff;
   logic [CSW-1:0]            s2_colsum_ff;
   logic [PW-1:0]             s2_pair_ff;
   bf3_pkg::meta_type         s2_meta_ff;

   logic                      issue;
   logic                      s1_go;
   logic                      s2_ready;
   logic                      endcol;
   logic                      lastrow;
   logic                      row_zero;
   logic                      row_ge2;
   bf3_pkg::meta_type         meta_in;
   logic [CSW-1:0]            colsum;
   logic [PW-1:0]             pair;
   logic [VW-1:0]             rd_older;
   logic [VW-1:0]             rd_newer;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_go    = s1_valid_ff && s2_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign issue    = in_valid && in_ready;

   assign endcol   = (col_ff == wlast);
   assign lastrow  = (row_ff == hlast);
   assign row_zero = (row_ff == '0);
   assign row_ge2  = !row_zero && (row_ff != 16'd1);

   always_comb begin
      meta_in.row      = row_ff;
      meta_in.col_a    = bf3_pkg::COL_W'(col_ff - CW'(1));
      meta_in.col_b    = bf3_pkg::COL_W'(wlast);
      meta_in.col_c    = bf3_pkg::COL_W'(col_ff);
      meta_in.emit_a   = row_ge2 && (col_ff != '0);
      meta_in.emit_b   = row_ge2 && endcol;
      meta_in.emit_c   = row_zero || lastrow;
      meta_in.interior = (col_ff >= CW'(2));
      meta_in.endcol   = endcol;
      meta_in.last     = lastrow && endcol;
   end

   // advance raster position
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (issue) begin
         if (endcol) begin
            col_ff <= '0;
            row_ff <= lastrow ? '0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= line_mem[col_ff];
      end
      if (s1_go) begin
         line_mem[s1_addr_ff] <= {rd_newer, s1_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_x_ff    <= in_sample;
         s1_addr_ff <= col_ff;
         s1_meta_ff <= meta_in;
      end
   end

   assign rd_older = rd_ff[2*VW-1:VW];
   assign rd_newer = rd_ff[VW-1:0];
   assign colsum   = CSW'(rd_older) + CSW'(rd_newer) + CSW'(s1_x_ff);
   assign pair     = PW'(prev_ff) + PW'(prev2_ff);

   // shift column sums, drop them at row end
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         prev_ff  <= '0;
         prev2_ff <= '0;
      end else if (s1_go) begin
         if (s1_meta_ff.endcol) begin
            prev_ff  <= '0;
            prev2_ff <= '0;
         end else begin
            prev_ff  <= colsum;
            prev2_ff <= prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_go;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_colsum_ff <= colsum;
         s2_pair_ff   <= pair;
         s2_meta_ff   <= s1_meta_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_sum   = SW'(s2_colsum_ff) + SW'(s2_pair_ff) + SW'(4);
   assign out_meta  = s2_meta_ff;

endmodule

`default_nettype wire

// File: src/bf3_div9.sv
`default_nettype none

module bf3_div9 #(
   parameter int VALUE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [VALUE_BITS+3:0] in_sum,
   input  bf3_pkg::meta_type     in_meta,
   output logic                  in_ready,
   output logic                  out_valid,
   output logic [VALUE_BITS-1:0] out_value,
   output bf3_pkg::meta_type     out_meta,
   input  logic                  out_ready
);

   localparam int SW  = VALUE_BITS + 4;
   localparam int MW  = SW - 3;
   localparam int PRW = SW + MW;
   localparam logic [MW-1:0] RECIP = MW'((64'd1 << SW) / 64'd9);

   logic              s3_valid_ff;
   logic [SW-1:0]     s3_n_ff;
   bf3_pkg::meta_type s3_meta_ff;

   logic              s4_valid_ff;
   logic [SW-1:0]     s4_n_ff;
   logic [PRW-1:0]    s4_prod_ff;
   bf3_pkg::meta_type s4_meta_ff;

   logic              s3_ready;
   logic              s4_ready;
   logic              s3_go;
   logic [MW-1:0]     q0;
   logic [SW-1:0]     nine_q;
   logic [SW-1:0]     rem;
   logic [MW-1:0]     q;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s3_go    = s3_valid_ff && s4_ready;
   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s3_ready) begin
         s3_n_ff    <= in_sum;
         s3_meta_ff <= in_meta;
      end
      if (s3_go) begin
         s4_n_ff    <= s3_n_ff;
         s4_prod_ff <= PRW'(s3_n_ff) * PRW'(RECIP);
         s4_meta_ff <= s3_meta_ff;
      end
   end

   // estimate may fall one short; fix with one compare
   assign q0     = s4_prod_ff[PRW-1:SW];
   assign nine_q = SW'({q0, 3'b000}) + SW'(q0);
   assign rem    = s4_n_ff - nine_q;
   assign q      = q0 + MW'(rem >= SW'(9));

   assign out_valid = s4_valid_ff;
   assign out_value = VALUE_BITS'(q);
   assign out_meta  = s4_meta_ff;

endmodule

`default_nettype wire

// File: src/bf3_emit.sv
`default_nettype none

module bf3_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [bf3_pkg::OUT_VALUE_W-1:0]   in_value,
   input  bf3_pkg::meta_type                 in_meta,
   output logic                              in_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bf3_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [bf3_pkg::COL_W-1:0]         rsp_out_col,
   output logic [bf3_pkg::OUT_VALUE_W-1:0]   rsp_smoothed_value,
   output logic                              rsp_frame_last
);

   logic [2:0]                         pend_ff;
   logic [2:0]                         pend_in;
   bf3_pkg::meta_type                  meta_ff;
   logic [bf3_pkg::OUT_VALUE_W-1:0]    value_ff;

   logic take;
   logic single;
   logic load;

   assign rsp_valid = (pend_ff != 3'b000);
   assign take      = rsp_valid && !rsp_stall;
   assign single    = (pend_ff == 3'b001) || (pend_ff == 3'b010) || (pend_ff == 3'b100);
   assign in_ready  = !rsp_valid || (take && single);
   assign load      = in_valid && in_ready;

   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = {in_meta.emit_c, in_meta.emit_b, in_meta.emit_a};
      end else if (take) begin
         pend_in = pend_ff & (pend_ff - 3'b001);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'b000;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff  <= in_meta;
         value_ff <= in_value;
      end
   end

   always_comb begin
      rsp_out_row        = meta_ff.row;
      rsp_out_col        = meta_ff.col_c;
      rsp_smoothed_value = '0;
      rsp_frame_last     = 1'b0;
      priority if (pend_ff[0]) begin
         rsp_out_row        = meta_ff.row - 16'd1;
         rsp_out_col        = meta_ff.col_a;
         rsp_smoothed_value = meta_ff.interior ? value_ff : '0;
      end else if (pend_ff[1]) begin
         rsp_out_row = meta_ff.row - 16'd1;
         rsp_out_col = meta_ff.col_b;
      end else begin
         rsp_frame_last = meta_ff.last;
      end
   end

endmodule

`default_nettype wire

// File: src/box_filter_3x3_zero_border.sv
// 3x3 box filter with zero border over a raster stream of grid samples.
// req channel: one unsigned Q16.8 sample per word, raster order, accepted when
// req_valid is high and req_stall is low. rsp channel: one smoothed value per
// word with its row and column; rsp_frame_last marks the final word of a frame.
// csr channel: index 0 sets grid_width, 1 sets grid_height; a write to either
// restarts the frame at row 0, column 0. Write only while the block is idle.
// Row 0 gives zeros at once; row 1 gives no word; from row 2 each sample past
// column 0 gives the word one row up and one column left, the mean or, in
// column 0, zero; the last column and last row add zeros.
// Throughput: one sample per cycle while each sample yields at most one word
// and rsp_stall is low; the output stage sends one word per cycle unless
// stalled, so a sample that yields two or three words holds the pipeline.
// The line store is one memory of both previous rows, read when the sample is
// accepted and written back as the sample leaves the first stage.
// An input skid register keeps req_stall registered; rsp_stall backs up the
// pipeline and, once the skid is full, raises req_stall. A stalled rsp word
// holds. Reset empties the pipeline, sets width and height to 64 and the
// position to row 0, column 0; line store contents are kept undefined.
`default_nettype none

module box_filter_3x3_zero_border #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [VALUE_BITS-1:0]             req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bf3_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [bf3_pkg::COL_W-1:0]         rsp_out_col,
   output logic [bf3_pkg::OUT_VALUE_W-1:0]   rsp_smoothed_value,
   output logic                              rsp_frame_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bf3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bf3_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int WIDTH_RESET = (64 < MAX_WIDTH) ? 64 : MAX_WIDTH;
   localparam logic [CW-1:0] WLAST_RESET = CW'(WIDTH_RESET - 1);

   logic [CW-1:0]             wlast_ff;
   logic [CW-1:0]             wlast_in;
   logic [bf3_pkg::ROW_W-1:0] hlast_ff;
   logic [bf3_pkg::ROW_W-1:0] hlast_in;
   logic                      csr_write;
   logic                      restart;

   logic                      skid_valid_ff;
   logic [VALUE_BITS-1:0]     skid_sample_ff;

   logic                      front_valid;
   logic [VALUE_BITS-1:0]     front_sample;
   logic                      win_ready;
   logic                      req_take;

   logic                      win_valid;
   logic [VALUE_BITS+3:0]     win_sum;
   bf3_pkg::meta_type         win_meta;
   logic                      div_ready;

   logic                      div_valid;
   logic [VALUE_BITS-1:0]     div_value;
   bf3_pkg::meta_type         div_meta;
   logic                      emit_ready;

   int unsigned               width_eff;
   logic [bf3_pkg::ROW_W-1:0] height_eff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write &&
                      ((csr_index == bf3_pkg::CSR_GRID_WIDTH) ||
                       (csr_index == bf3_pkg::CSR_GRID_HEIGHT));

   always_comb begin
      width_eff = 32'(csr_data[bf3_pkg::WIDTH_REG_W-1:0]);
      if (width_eff < 32'd3) begin
         width_eff = 32'd3;
      end
      if (width_eff > 32'(MAX_WIDTH)) begin
         width_eff = 32'(MAX_WIDTH);
      end
      wlast_in = CW'(width_eff - 32'd1);

      height_eff = csr_data;
      if (height_eff < bf3_pkg::HEIGHT_MIN) begin
         height_eff = bf3_pkg::HEIGHT_MIN;
      end
      hlast_in = height_eff - 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= WLAST_RESET;
         hlast_ff <= bf3_pkg::HEIGHT_RESET - 16'd1;
      end else if (csr_write) begin
         if (csr_index == bf3_pkg::CSR_GRID_WIDTH) begin
            wlast_ff <= wlast_in;
         end
         if (csr_index == bf3_pkg::CSR_GRID_HEIGHT) begin
            hlast_ff <= hlast_in;
         end
      end
   end

   // hold a word in the skid when the pipeline is full
   assign req_stall    = skid_valid_ff;
   assign req_take     = req_valid && !req_stall;
   assign front_valid  = skid_valid_ff || req_valid;
   assign front_sample = skid_valid_ff ? skid_sample_ff : req_sample_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (win_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take && !win_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && !win_ready) begin
         skid_sample_ff <= req_sample_value;
      end
   end

   bf3_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .wlast     (wlast_ff),
      .hlast     (hlast_ff),
      .in_valid  (front_valid),
      .in_sample (front_sample),
      .in_ready  (win_ready),
      .out_valid (win_valid),
      .out_sum   (win_sum),
      .out_meta  (win_meta),
      .out_ready (div_ready)
   );

   bf3_div9 #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div9 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_sum    (win_sum),
      .in_meta   (win_meta),
      .in_ready  (div_ready),
      .out_valid (div_valid),
      .out_value (div_value),
      .out_meta  (div_meta),
      .out_ready (emit_ready)
   );

   bf3_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (div_valid),
      .in_value           (bf3_pkg::OUT_VALUE_W'(div_value)),
      .in_meta            (div_meta),
      .in_ready           (emit_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_frame_last     (rsp_frame_last)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;

   localparam int SAMPLE_W      = 24;
   localparam int MAX_COLS      = 1024;
   localparam int WIDTH_RESET   = 64;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [bf3_pkg::CSR_INDEX_W-1:0] CSR_SPARE  = 2'd2;
   localparam logic [SAMPLE_W-1:0]             SAMPLE_MAX = '1;

   typedef struct packed {
      logic [bf3_pkg::ROW_W-1:0]       row;
      logic [bf3_pkg::COL_W-1:0]       col;
      logic [bf3_pkg::OUT_VALUE_W-1:0] value;
      logic                            last;
   } grid_word_type;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   logic [SAMPLE_W-1:0]             req_sample_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   logic [bf3_pkg::ROW_W-1:0]       rsp_out_row;
   logic [bf3_pkg::COL_W-1:0]       rsp_out_col;
   logic [bf3_pkg::OUT_VALUE_W-1:0] rsp_smoothed_value;
   logic                            rsp_frame_last;
   logic                            csr_valid        = 1'b0;
   logic                            csr_ready;
   logic [bf3_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [bf3_pkg::CSR_DATA_W-1:0]  csr_data         = '0;

   logic [SAMPLE_W-1:0]             older_line [MAX_COLS];
   logic [SAMPLE_W-1:0]             newer_line [MAX_COLS];
   logic [25:0]                     col_sum_1;
   logic [25:0]                     col_sum_2;
   int unsigned                     at_row;
   int unsigned                     at_col;
   logic [bf3_pkg::WIDTH_REG_W-1:0] width_setting;
   logic [bf3_pkg::ROW_W-1:0]       height_setting;
   grid_word_type                   due_words [$];

   int errors            = 0;
   int sent_items        = 0;
   int quiet_cycles      = 0;
   int sink_hold_request = 0;
   int hold_left         = 0;
   int stall_left        = 0;
   bit src_gaps          = 1'b0;
   bit sink_stalls       = 1'b0;

   box_filter_3x3_zero_border #(
      .MAX_WIDTH  (MAX_COLS),
      .VALUE_BITS (SAMPLE_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_frame_last     (rsp_frame_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void restart_position();
      at_row    = 0;
      at_col    = 0;
      col_sum_1 = '0;
      col_sum_2 = '0;
   endfunction

   function automatic void push_word(input int unsigned row, input int unsigned col,
                                     input logic [bf3_pkg::OUT_VALUE_W-1:0] value,
                                     input logic last);
      grid_word_type word;
      word.row   = bf3_pkg::ROW_W'(row);
      word.col   = bf3_pkg::COL_W'(col);
      word.value = value;
      word.last  = last;
      due_words  = {due_words, word};
   endfunction

   function automatic void predict_smoothing(input logic [SAMPLE_W-1:0] x);
      int unsigned                     w;
      int unsigned                     h;
      int unsigned                     r;
      int unsigned                     c;
      logic [25:0]                     col_sum;
      logic [31:0]                     box_sum;
      logic [bf3_pkg::OUT_VALUE_W-1:0] mean;
      w = 32'(width_setting);
      if (w < 3) w = 3;
      if (w > MAX_COLS) w = MAX_COLS;
      h = 32'(height_setting);
      if (h < 3) h = 3;
      r = at_row;
      c = at_col;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      col_sum = 26'(older_line[c]) + 26'(newer_line[c]) + 26'(x);
      if (r == 0) begin
         push_word(0, c, '0, 1'b0);
      end else if (r >= 2) begin
         if (c >= 1) begin
            mean = '0;
            if (c - 1 >= 1 && c - 1 <= w - 2) begin
               box_sum = 32'(col_sum_2) + 32'(col_sum_1) + 32'(col_sum);
               mean    = bf3_pkg::OUT_VALUE_W'((box_sum + 32'd4) / 32'd9);
            end
            push_word(r - 1, c - 1, mean, 1'b0);
         end
         if (c == w - 1) push_word(r - 1, w - 1, '0, 1'b0);
         if (r == h - 1) push_word(r, c, '0, c == w - 1);
      end
      older_line[c] = newer_line[c];
      newer_line[c] = x;
      col_sum_2     = col_sum_1;
      col_sum_1     = col_sum;
      if (c + 1 >= w) begin
         at_col    = 0;
         col_sum_1 = '0;
         col_sum_2 = '0;
         at_row    = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         at_col = c + 1;
         at_row = r;
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return SAMPLE_MAX;
         end
         2: begin
            return SAMPLE_W'($urandom_range(0, 255));
         end
         3: begin
            return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
         end
         default: begin
            return SAMPLE_W'($urandom());
         end
      endcase
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = src_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      do @(posedge clock); while (req_stall);
      predict_smoothing(value);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      do @(negedge clock); while (due_words.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bf3_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bf3_pkg::CSR_DATA_W-1:0] data);
      wait_drained(1'b1);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         bf3_pkg::CSR_GRID_WIDTH: begin
            width_setting = data[bf3_pkg::WIDTH_REG_W-1:0];
            restart_position();
         end
         bf3_pkg::CSR_GRID_HEIGHT: begin
            height_setting = data;
            restart_position();
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_geometry();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      repeat (WIDTH_RESET + 6) send_sample(random_sample());
   endtask

   task automatic test_directed_frames();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      write_csr(bf3_pkg::CSR_GRID_WIDTH, '0);
      write_csr(bf3_pkg::CSR_GRID_HEIGHT, 16'd1);
      repeat (9) send_sample(SAMPLE_MAX);
      repeat (3) send_sample('0);
      send_sample(SAMPLE_MAX);
      // restart mid-frame, then a write to an unused index must not disturb it
      write_csr(bf3_pkg::CSR_GRID_WIDTH, 16'd4);
      send_sample(SAMPLE_MAX);
      send_sample(24'h000001);
      write_csr(CSR_SPARE, '1);
      for (int i = 0; i < 10; i++) begin
         send_sample(i[0] ? SAMPLE_MAX : SAMPLE_W'(i * 5));
      end
   endtask

   task automatic test_widest_row();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      write_csr(bf3_pkg::CSR_GRID_WIDTH, '1);
      write_csr(bf3_pkg::CSR_GRID_HEIGHT, '1);
      repeat (40) send_sample(random_sample());
   endtask

   task automatic test_random_frames();
      int unsigned w_code;
      int unsigned h_code;
      int          frame_items;
      int          stop_at;
      stop_at = sent_items + 250;
      while (sent_items < stop_at) begin
         src_gaps    = $urandom_range(0, 3) != 0;
         sink_stalls = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 7))
            0: begin
               w_code = $urandom_range(0, 3);
            end
            1: begin
               w_code = $urandom_range(11, 40);
            end
            default: begin
               w_code = $urandom_range(3, 10);
            end
         endcase
         h_code = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 7);
         write_csr(bf3_pkg::CSR_GRID_WIDTH, bf3_pkg::CSR_DATA_W'(w_code));
         write_csr(bf3_pkg::CSR_GRID_HEIGHT, bf3_pkg::CSR_DATA_W'(h_code));
         frame_items = ((w_code < 3) ? 3 : w_code) * ((h_code < 3) ? 3 : h_code);
         if ($urandom_range(0, 4) == 0) begin
            frame_items = $urandom_range(1, frame_items - 1);
         end else if ($urandom_range(0, 3) == 0) begin
            frame_items = 2 * frame_items;
         end
         if (frame_items > stop_at - sent_items) begin
            frame_items = stop_at - sent_items;
         end
         repeat (frame_items) send_sample(random_sample());
      end
   endtask

   task automatic test_backpressure();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      write_csr(bf3_pkg::CSR_GRID_WIDTH, 16'd8);
      write_csr(bf3_pkg::CSR_GRID_HEIGHT, 16'd8);
      @(posedge clock);
      sink_hold_request = 200;
      @(negedge clock);
      repeat (40) send_sample(random_sample());
      wait_drained(1'b0);
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      repeat (24) send_sample(random_sample());
   endtask

   always @(negedge clock) begin
      if (sink_hold_request > 0) begin
         hold_left         = sink_hold_request;
         sink_hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!sink_stalls) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
   end

   always @(posedge clock) begin : check_words
      grid_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected word: row %0d col %0d value %h last %b",
                        rsp_out_row, rsp_out_col, rsp_smoothed_value, rsp_frame_last);
            end
         end else begin
            want = due_words.pop_front();
            if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                rsp_smoothed_value !== want.value || rsp_frame_last !== want.last) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("mismatch: expected row %0d col %0d value %h last %b",
                           want.row, want.col, want.value, want.last);
                  $display("          got      row %0d col %0d value %h last %b",
                           rsp_out_row, rsp_out_col, rsp_smoothed_value, rsp_frame_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("** box_filter_3x3_zero_border: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < MAX_COLS; i++) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      width_setting  = bf3_pkg::WIDTH_REG_W'(WIDTH_RESET);
      height_setting = bf3_pkg::HEIGHT_RESET;
      restart_position();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_directed_frames();
      test_widest_row();
      test_random_frames();
      test_backpressure();

      wait_drained(1'b1);
      errors += due_words.size();
      if (errors == 0) begin
         $display("** box_filter_3x3_zero_border: PASSED **");
      end else begin
         $display("** box_filter_3x3_zero_border: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
src/bf3_pkg.sv
src/bf3_window.sv
src/bf3_div9.sv
src/bf3_emit.sv
src/box_filter_3x3_zero_border.sv
dv/tb.sv
